[design/ssi_pkg.sv]
`default_nettype none

package ssi_pkg;

    // Default list capacity, terminator included
    localparam int MAX_SPANS_DEF = 32;

    // Field widths
    localparam int POS_W = 16;
    localparam int COL_W = 8;
    localparam int IN_W  = 17;

    // Fixed list values
    localparam logic [POS_W-1:0] TERM_END  = 16'hffff;
    localparam logic [COL_W-1:0] TERM_COL  = 8'd0;
    localparam logic [IN_W-1:0]  TOP_POS   = 17'd65534;

    // Action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_EMIT  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_FIT,
        S_MOVE,
        S_WHEAD,
        S_WNEW,
        S_EMIT
    } t_state;

    // Write strobes and data for the end and colour memories
    typedef struct packed {
        logic             end_we;
        logic             col_we;
        logic [POS_W-1:0] end_d;
        logic [COL_W-1:0] col_d;
    } t_wr_ctl;

    // One result item
    typedef struct packed {
        logic [COL_W-1:0] colour;
        logic [POS_W-1:0] span_end;
        logic             last;
        logic             ovf;
    } t_span_res;

endpackage

`default_nettype wire

[design/ssi_ram.sv]
`default_nettype none

module ssi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/ssi_oreg.sv]
`default_nettype none

module ssi_oreg
    import ssi_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_span_res i_res,
    output logic           o_room,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_span_res      o_res
);

    logic      r_valid;
    t_span_res r_res;

    // Free when empty or being taken this cycle
    assign o_room = !r_valid || !i_stall;

    // Hold the item until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

[design/ssi_seq.sv]
`default_nettype none

module ssi_seq
    import ssi_pkg::*;
#(
    parameter int MAX_SPANS = MAX_SPANS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [1:0]                   i_action,
    input  wire logic signed [IN_W-1:0]       i_x_start,
    input  wire logic signed [IN_W-1:0]       i_x_end,
    input  wire logic [COL_W-1:0]             i_paint_colour,
    output logic                              o_rd_en,
    output logic [$clog2(MAX_SPANS)-1:0]      o_rd_addr,
    input  wire logic [POS_W-1:0]             i_rd_end,
    input  wire logic [COL_W-1:0]             i_rd_col,
    output logic [$clog2(MAX_SPANS)-1:0]      o_wr_addr,
    output t_wr_ctl                           o_wr,
    output logic                              o_res_load,
    output t_span_res                         o_res,
    input  wire logic                         i_res_room
);

    localparam int AW = $clog2(MAX_SPANS);
    localparam int CW = $clog2(MAX_SPANS + 1);

    t_state r_state, n_state;

    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic [AW-1:0]    r_idx;
    logic             r_hf;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    r_tail;
    logic [POS_W-1:0] r_xs;
    logic [POS_W-1:0] r_xe;
    logic [COL_W-1:0] r_col;
    logic [CW-1:0]    r_newcount;
    logic [AW-1:0]    r_ofs;
    logic             r_down;
    logic [AW-1:0]    r_src;
    logic [AW-1:0]    r_wdst;
    logic [CW-1:0]    r_left;
    logic             r_pend;

    logic signed [IN_W-1:0] xe_sat;
    logic                   drop;
    logic [POS_W-1:0]       xs_clamp;
    logic [CW-1:0]          cnt_m1;
    logic [AW-1:0]          last_idx;
    logic                   one_entry;
    logic                   ge_xs;
    logic                   hf_now;
    logic                   tail_hit;
    logic                   scan_end;
    logic [CW:0]            new_cnt;
    logic                   too_big;
    logic                   no_move;
    logic                   move_down;
    logic                   is_last;

    // Saturate, clamp and screen the incoming add
    always_comb begin
        xe_sat   = (i_x_end > $signed(TOP_POS)) ? $signed(TOP_POS) : i_x_end;
        drop     = xe_sat[IN_W-1] || (i_x_start > xe_sat);
        xs_clamp = i_x_start[IN_W-1] ? '0 : i_x_start[POS_W-1:0];
    end

    // List bookkeeping
    assign cnt_m1    = r_count - CW'(1);
    assign last_idx  = cnt_m1[AW-1:0];
    assign one_entry = (r_count == CW'(1));

    // Scan compare on the entry read last cycle
    assign ge_xs    = (i_rd_end >= r_xs);
    assign hf_now   = r_hf || ge_xs;
    assign tail_hit = hf_now && (i_rd_end > r_xe);
    assign scan_end = ((r_idx + AW'(1)) == last_idx);

    // Size of the list after the add and direction of the shift
    assign new_cnt   = {1'b0, r_count} + (CW+1)'(2) + (CW+1)'(r_head) - (CW+1)'(r_tail);
    assign too_big   = (new_cnt > (CW+1)'(MAX_SPANS));
    assign no_move   = ((AW+1)'(r_tail) == ((AW+1)'(r_head) + (AW+1)'(2)));
    assign move_down = ((AW+1)'(r_tail) < ((AW+1)'(r_head) + (AW+1)'(2)));

    assign is_last = (r_idx == last_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_action)
                        ACT_ADD: begin
                            if (drop) begin
                                n_state = S_IDLE;
                            end else if (one_entry) begin
                                n_state = S_FIT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_EMIT: begin
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (tail_hit || scan_end) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (too_big) begin
                    n_state = S_IDLE;
                end else if (no_move) begin
                    n_state = S_WHEAD;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (r_left == '0) begin
                    n_state = S_WHEAD;
                end
            end
            S_WHEAD: begin
                n_state = S_WNEW;
            end
            S_WNEW: begin
                n_state = S_IDLE;
            end
            S_EMIT: begin
                if (i_res_room && is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory controls and result item
    always_comb begin
        o_stall        = 1'b1;
        o_rd_en        = 1'b0;
        o_rd_addr      = '0;
        o_wr_addr      = '0;
        o_wr.end_we    = 1'b0;
        o_wr.col_we    = 1'b0;
        o_wr.end_d     = i_rd_end;
        o_wr.col_d     = i_rd_col;
        o_res_load     = 1'b0;
        o_res.colour   = is_last ? TERM_COL : i_rd_col;
        o_res.span_end = is_last ? TERM_END : i_rd_end;
        o_res.last     = is_last;
        o_res.ovf      = r_ovf;
        case (r_state)
            S_INIT: begin
                o_wr.end_we = 1'b1;
                o_wr.col_we = 1'b1;
                o_wr.end_d  = TERM_END;
                o_wr.col_d  = TERM_COL;
            end
            S_IDLE: begin
                o_stall = 1'b0;
                o_rd_en = 1'b1;
                if (i_valid && (i_action == ACT_CLEAR)) begin
                    o_wr.end_we = 1'b1;
                    o_wr.col_we = 1'b1;
                    o_wr.end_d  = TERM_END;
                    o_wr.col_d  = TERM_COL;
                end
            end
            S_SCAN: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_idx + AW'(1);
            end
            S_MOVE: begin
                o_rd_en     = (r_left != '0);
                o_rd_addr   = r_src;
                o_wr_addr   = r_wdst;
                o_wr.end_we = r_pend;
                o_wr.col_we = r_pend;
            end
            S_WHEAD: begin
                o_wr_addr   = r_head;
                o_wr.end_we = 1'b1;
                o_wr.end_d  = r_xs;
            end
            S_WNEW: begin
                o_wr_addr   = r_head + AW'(1);
                o_wr.end_we = 1'b1;
                o_wr.col_we = 1'b1;
                o_wr.end_d  = r_xe;
                o_wr.col_d  = r_col;
            end
            S_EMIT: begin
                o_res_load = i_res_room;
                o_rd_en    = i_res_room;
                o_rd_addr  = r_idx + AW'(1);
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_INIT: begin
                    r_count <= CW'(1);
                end
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_action)
                            ACT_CLEAR: begin
                                r_count <= CW'(1);
                                r_ovf   <= 1'b0;
                            end
                            ACT_ADD: begin
                                r_xs   <= xs_clamp;
                                r_xe   <= xe_sat[POS_W-1:0];
                                r_col  <= i_paint_colour;
                                r_idx  <= '0;
                                r_hf   <= 1'b0;
                                r_head <= '0;
                                r_tail <= '0;
                            end
                            ACT_EMIT: begin
                                r_idx <= '0;
                            end
                            default: begin
                                r_idx <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Record the cut point, then the first entry past the span
                    if (!r_hf && ge_xs) begin
                        r_head <= r_idx;
                    end
                    if (tail_hit) begin
                        r_tail <= r_idx;
                    end else if (scan_end) begin
                        if (!hf_now) begin
                            r_head <= last_idx;
                        end
                        r_tail <= last_idx;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                        r_hf  <= hf_now;
                    end
                end
                S_FIT: begin
                    if (too_big) begin
                        r_ovf <= 1'b1;
                    end
                    r_newcount <= new_cnt[CW-1:0];
                    r_ofs      <= r_head + AW'(2) - r_tail;
                    r_down     <= move_down;
                    r_src      <= move_down ? last_idx : r_tail;
                    r_left     <= r_count - CW'(r_tail);
                    r_pend     <= 1'b0;
                end
                S_MOVE: begin
                    // Read one entry, write the one read last cycle
                    if (r_left != '0) begin
                        r_src  <= r_down ? (r_src - AW'(1)) : (r_src + AW'(1));
                        r_wdst <= r_src + r_ofs;
                        r_left <= r_left - CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                S_WNEW: begin
                    r_count <= r_newcount;
                end
                S_EMIT: begin
                    if (i_res_room) begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/scanline_span_insert_unit.sv]
// Scanline span list: keeps one line as an ordered list of (end, colour) spans.
// Input channel i_valid / o_stall carries one item: i_action, i_x_start,
// i_x_end, i_paint_colour. Output channel o_valid / i_stall carries results:
// o_span_colour, o_span_end, o_last, o_overflowed.
// A clear or a dropped add is handled in the idle state. An add that finds no
// room ends after its scan and the sizing step. Any other add scans entries to
// find the cut point, sizes the result, shifts the later entries if needed in the
// list memory (one read and one write port), finishing the last write, then
// makes two writes for the cut and the new span. An emit gives one result per
// list entry, one per cycle while the receiver does not stall, the terminator
// last; the first result is presented from the output register after the
// sequencer enters its emit state. New items are taken only between items, but
// a finished result may still wait in the output register. After reset the
// block writes the terminator into the list memory with o_stall high, then
// holds the lone terminator. When the receiver stalls, the output register
// holds its result and an emit in progress pauses until there is room.
`default_nettype none

module scanline_span_insert_unit
    import ssi_pkg::*;
#(
    parameter int MAX_SPANS = MAX_SPANS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_action,
    input  wire logic signed [IN_W-1:0] i_x_start,
    input  wire logic signed [IN_W-1:0] i_x_end,
    input  wire logic [COL_W-1:0]       i_paint_colour,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [COL_W-1:0]            o_span_colour,
    output logic [POS_W-1:0]            o_span_end,
    output logic                        o_last,
    output logic                        o_overflowed
);

    localparam int AW = $clog2(MAX_SPANS);

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [POS_W-1:0] rd_end;
    logic [COL_W-1:0] rd_col;
    logic [AW-1:0]    wr_addr;
    t_wr_ctl          wr;
    logic             res_load;
    logic             res_room;
    t_span_res        res;
    t_span_res        out_res;

    // Span end positions
    ssi_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_SPANS)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (wr.end_we),
        .i_waddr (wr_addr),
        .i_wdata (wr.end_d),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_end)
    );

    // Span colours
    ssi_ram #(
        .WIDTH (COL_W),
        .DEPTH (MAX_SPANS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (wr.col_we),
        .i_waddr (wr_addr),
        .i_wdata (wr.col_d),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_col)
    );

    // Scan, shift and emit sequencer
    ssi_seq #(
        .MAX_SPANS (MAX_SPANS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_x_start      (i_x_start),
        .i_x_end        (i_x_end),
        .i_paint_colour (i_paint_colour),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_end       (rd_end),
        .i_rd_col       (rd_col),
        .o_wr_addr      (wr_addr),
        .o_wr           (wr),
        .o_res_load     (res_load),
        .o_res          (res),
        .i_res_room     (res_room)
    );

    // Output register
    ssi_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (res),
        .o_room  (res_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_span_colour = out_res.colour;
    assign o_span_end    = out_res.span_end;
    assign o_last        = out_res.last;
    assign o_overflowed  = out_res.ovf;

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ssi_pkg::*;

    localparam int         SPAN_CAP = MAX_SPANS_DEF;
    localparam int         N_ITEMS  = 420;
    localparam int         HOLD_CYC = 300;
    localparam int         N_ROWS   = 22;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    typedef t_span_res [0:2] t_trio;

    // One row of the directed table; a row with reps > 1 steps both ends by step
    typedef struct packed {
        logic [1:0]             act;
        logic signed [IN_W-1:0] xs;
        logic signed [IN_W-1:0] xe;
        logic [COL_W-1:0]       col;
        logic [4:0]             reps;
        logic [7:0]             step;
        logic [1:0]             n_typed;
        t_trio                  typed;
    } t_stim_row;

    localparam t_span_res R_NIL  = '0;
    localparam t_span_res R_TERM = '{TERM_COL, TERM_END, 1'b1, 1'b0};
    localparam t_span_res R_CUT0 = '{8'h00, 16'd0, 1'b0, 1'b0};
    localparam t_span_res R_FULL = '{8'hff, 16'd65534, 1'b0, 1'b0};
    localparam t_trio     NO_TYPED  = '0;
    localparam t_trio     ONLY_TERM = '{R_TERM, R_NIL, R_NIL};
    localparam t_trio     FULL_LINE = '{R_CUT0, R_FULL, R_TERM};

    // Directed items: extremes, dropped adds, zero-length spans, fill and overflow
    localparam t_stim_row STIM_TABLE [N_ROWS] = '{
        '{ACT_EMIT, 17'sd0,      17'sd0,      8'h00, 5'd1,  8'd0,  2'd1, ONLY_TERM},
        '{ACT_ADD,  17'h10000,   17'h0ffff,   8'hff, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_EMIT, 17'sd0,      17'sd0,      8'h00, 5'd1,  8'd0,  2'd3, FULL_LINE},
        '{ACT_ADD,  17'sd5,      17'sd4,      8'h01, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_ADD,  17'h1fff6,   17'h1ffff,   8'h02, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_ADD,  17'h0ffff,   17'h0ffff,   8'h03, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_NOP,  17'sd12345,  17'h1fffd,   8'h5a, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_EMIT, 17'sd0,      17'sd0,      8'h00, 5'd1,  8'd0,  2'd3, FULL_LINE},
        '{ACT_CLEAR, 17'sd0,     17'sd0,      8'h00, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_ADD,  17'sd100,    17'sd100,    8'h55, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_ADD,  17'sd100,    17'sd200,    8'haa, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_ADD,  17'sd0,      17'sd0,      8'h01, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_ADD,  17'sd65534,  17'h0ffff,   8'h00, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_EMIT, 17'sd0,      17'sd0,      8'h00, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_CLEAR, 17'sd0,     17'sd0,      8'h00, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_ADD,  17'sd1000,   17'sd1001,   8'h07, 5'd15, 8'd10, 2'd0, NO_TYPED},
        '{ACT_ADD,  17'sd1135,   17'sd1140,   8'h09, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_EMIT, 17'sd0,      17'sd0,      8'h00, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_ADD,  17'sd2000,   17'sd2001,   8'h03, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_EMIT, 17'sd0,      17'sd0,      8'h00, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_CLEAR, 17'sd0,     17'sd0,      8'h00, 5'd1,  8'd0,  2'd0, NO_TYPED},
        '{ACT_EMIT, 17'sd0,      17'sd0,      8'h00, 5'd1,  8'd0,  2'd1, ONLY_TERM}
    };

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic [1:0]             i_action       = ACT_CLEAR;
    logic signed [IN_W-1:0] i_x_start      = '0;
    logic signed [IN_W-1:0] i_x_end        = '0;
    logic [COL_W-1:0]       i_paint_colour = '0;
    logic                   i_stall        = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [COL_W-1:0]       o_span_colour;
    logic [POS_W-1:0]       o_span_end;
    logic                   o_last;
    logic                   o_overflowed;

    int   tx_idle_pct = 23;
    int   rx_idle_pct = 73;
    int   items_sent  = 0;
    int   bad_count   = 0;
    logic hold_go     = 1'b0;
    logic hold_on     = 1'b0;

    // Span list as the block should hold it
    logic [POS_W-1:0] line_end [SPAN_CAP];
    logic [COL_W-1:0] line_col [SPAN_CAP];
    int               line_len;
    logic             line_ovf;
    t_span_res        span_q [$];

    scanline_span_insert_unit #(
        .MAX_SPANS(SPAN_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_x_start     (i_x_start),
        .i_x_end       (i_x_end),
        .i_paint_colour(i_paint_colour),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_span_colour (o_span_colour),
        .o_span_end    (o_span_end),
        .o_last        (o_last),
        .o_overflowed  (o_overflowed)
    );

    always #6 i_clk = ~i_clk;

    // Drop the list back to the lone terminator
    function automatic void reset_line();
        foreach (line_end[i]) begin
            line_end[i] = '0;
            line_col[i] = '0;
        end
        line_end[0] = TERM_END;
        line_col[0] = TERM_COL;
        line_len    = 1;
        line_ovf    = 1'b0;
    endfunction

    // Paint [xs, xe]: cut the entry holding xs, insert the span, drop covered entries
    function automatic void paint_span(logic signed [IN_W-1:0] xs_in,
                                       logic signed [IN_W-1:0] xe_in,
                                       logic [COL_W-1:0] col);
        int               xs, xe, head, tail, n_new;
        logic [POS_W-1:0] end_old [SPAN_CAP];
        logic [COL_W-1:0] col_old [SPAN_CAP];
        xs = int'(xs_in);
        xe = int'(xe_in);
        if (xe > int'(TOP_POS))
            xe = int'(TOP_POS);
        if (xe < 0 || xs > xe)
            return;
        if (xs < 0)
            xs = 0;
        head = 0;
        while (head + 1 < line_len && int'(line_end[head]) < xs)
            head++;
        tail = head;
        while (tail + 1 < line_len && int'(line_end[tail]) <= xe)
            tail++;
        n_new = head + 2 + line_len - tail;
        if (n_new > SPAN_CAP) begin
            line_ovf = 1'b1;
            return;
        end
        end_old = line_end;
        col_old = line_col;
        for (int i = 0; i < line_len - tail; i++) begin
            line_end[head + 2 + i] = end_old[tail + i];
            line_col[head + 2 + i] = col_old[tail + i];
        end
        line_end[head]     = POS_W'(xs);
        line_end[head + 1] = POS_W'(xe);
        line_col[head + 1] = col;
        line_len           = n_new;
    endfunction

    // Queue one expected span per list entry, terminator last
    function automatic void list_spans();
        for (int i = 0; i < line_len; i++) begin
            if (i == line_len - 1)
                span_q.push_back(t_span_res'{TERM_COL, TERM_END, 1'b1, line_ovf});
            else
                span_q.push_back(t_span_res'{line_col[i], line_end[i], 1'b0, line_ovf});
        end
    endfunction

    task automatic flag_error(string msg);
        bad_count++;
        if (bad_count <= 10)
            $display("%s", msg);
    endtask

    // Offer one item after a random gap, hold it until taken, then update the list
    task automatic send_item(logic [1:0] act, logic signed [IN_W-1:0] xs,
                             logic signed [IN_W-1:0] xe, logic [COL_W-1:0] col,
                             int n_typed, t_trio typed);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_x_start      <= xs;
        i_x_end        <= xe;
        i_paint_colour <= col;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        case (act)
            ACT_CLEAR: reset_line();
            ACT_ADD:   paint_span(xs, xe, col);
            ACT_EMIT: begin
                if (n_typed > 0) begin
                    for (int i = 0; i < n_typed; i++)
                        span_q.push_back(typed[i]);
                end else begin
                    list_spans();
                end
            end
            default: ;
        endcase
        if (act != ACT_NOP)
            items_sent++;
    endtask

    // Stop offering and wait until every expected span has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (span_q.size() != 0);
    endtask

    // Check each span taken by the receiver, then pick the next stall
    always @(posedge i_clk) begin : rx_side
        t_span_res got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = t_span_res'{o_span_colour, o_span_end, o_last, o_overflowed};
            if (span_q.size() == 0) begin
                flag_error($sformatf("unexpected span: colour %02h end %0d last %0b ovf %0b",
                                     got.colour, got.span_end, got.last, got.ovf));
            end else begin
                want = span_q.pop_front();
                if (got.colour !== want.colour || got.span_end !== want.span_end ||
                    got.last !== want.last || got.ovf !== want.ovf) begin
                    flag_error($sformatf({"span mismatch: want colour %02h end %0d last %0b",
                                          " ovf %0b, got colour %02h end %0d last %0b ovf %0b"},
                                         want.colour, want.span_end, want.last, want.ovf,
                                         got.colour, got.span_end, got.last, got.ovf));
                end
            end
        end
        i_stall <= hold_on || ($urandom_range(99) < rx_idle_pct);
    end

    // Hold the receiver off for a long stretch once asked
    initial begin : rx_hold
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Give up after a fixed budget
    initial begin : watchdog
        #7_200_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stim
        int   s, e, k, n_add, lim, sel;
        logic hold_done, drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        reset_line();

        // Hold reset, then release it
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int r = 0; r < N_ROWS; r++) begin
            for (int j = 0; j < int'(STIM_TABLE[r].reps); j++) begin
                s = int'(STIM_TABLE[r].xs) + j * int'(STIM_TABLE[r].step);
                e = int'(STIM_TABLE[r].xe) + j * int'(STIM_TABLE[r].step);
                send_item(STIM_TABLE[r].act, IN_W'(s), IN_W'(e), STIM_TABLE[r].col,
                          int'(STIM_TABLE[r].n_typed), STIM_TABLE[r].typed);
            end
        end

        // Random line drawing, mostly well-formed clear/add/emit runs
        while (items_sent < N_ITEMS) begin
            if (items_sent < N_ITEMS / 3) begin
                tx_idle_pct = 23;
                rx_idle_pct = 73;
            end else if (items_sent < 2 * N_ITEMS / 3) begin
                tx_idle_pct = 73;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (!hold_done && items_sent >= 3 * N_ITEMS / 4) begin
                hold_go   = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= 7 * N_ITEMS / 8) begin
                wait_drained();
                drain_done = 1'b1;
            end

            if ($urandom_range(99) < 75) begin
                if ($urandom_range(4) != 0)
                    send_item(ACT_CLEAR, '0, '0, '0, 0, NO_TYPED);
                n_add = ($urandom_range(4) == 0) ? $urandom_range(22, 14) : $urandom_range(8);
                lim   = ($urandom_range(1) == 1) ? 65535 : 255;
                for (k = 0; k < n_add; k++) begin
                    s = $urandom_range(lim);
                    e = s + $urandom_range(lim / 8 + 2);
                    if (e > 65535)
                        e = 65535;
                    sel = $urandom_range(9);
                    // Now and then start left of the line or past the end
                    if (sel == 0) begin
                        s = -int'($urandom_range(65536, 1));
                    end else if (sel == 1) begin
                        s = e + 1 + $urandom_range(3);
                        if (s > 65535)
                            s = 65535;
                    end
                    send_item(ACT_ADD, IN_W'(s), IN_W'(e), COL_W'($urandom), 0, NO_TYPED);
                    if ($urandom_range(7) == 0)
                        send_item(ACT_EMIT, '0, '0, '0, 0, NO_TYPED);
                end
                send_item(ACT_EMIT, '0, '0, '0, 0, NO_TYPED);
            end else begin
                // Noise: any action with any field values
                n_add = $urandom_range(4, 1);
                for (k = 0; k < n_add; k++)
                    send_item(2'($urandom), IN_W'($urandom), IN_W'($urandom),
                              COL_W'($urandom), 0, NO_TYPED);
            end
        end

        // Drain, let the block settle, then report
        wait_drained();
        repeat (2 * SPAN_CAP + 8) @(posedge i_clk);
        if (bad_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
